[rtl/core/rshd_pkg.sv]
// shared types, constants and codes of the radar spoke header decoder
`timescale 1ns / 1ps
`default_nettype none
package rshd_pkg;

  // header recognition
  localparam logic [7:0]         HDR_LEN        = 8'h18;
  localparam logic [7:0]         STATUS_PLAIN   = 8'h02;
  localparam logic [7:0]         STATUS_ALT     = 8'h12;
  localparam logic [31:0]        OLD_MARK       = 32'h0E0D4400;
  localparam logic signed [15:0] NARROW_FLAG    = 16'sh0080;
  localparam logic signed [15:0] HEADING_ABSENT = 16'sh8000;

  // rotation arithmetic
  localparam int unsigned SPOKE_BITS   = 12;
  localparam int unsigned SPOKE_COUNT  = 1 << SPOKE_BITS;
  localparam logic [SPOKE_BITS-1:0] ANGLE_OFFSET = SPOKE_BITS'(3 * SPOKE_COUNT / 4);

  // range decode
  localparam int unsigned RAW_W       = 24;
  localparam int unsigned RANGE_W     = 28;
  localparam int unsigned RANGE_SCALE = 50;
  localparam int unsigned SQRT_W      = 56;
  localparam int unsigned SQRT_STEPS  = SQRT_W / 2;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VARIATION       = 3'd0,
    CFG_VARIATION_VALID = 3'd1,
    CFG_IGNORE_HEADING  = 3'd2,
    CFG_ROTATION        = 3'd3,
    CFG_INITIAL_HEADING = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]         header_length;
    logic [7:0]         status_byte;
    logic [11:0]        seq_num;
    logic [31:0]        mark_word;
    logic [15:0]        angle_word;
    logic signed [15:0] heading_word;
    logic [31:0]        range_word;
  } hdr_t;

  typedef struct packed {
    logic                      spoke_drawn;
    logic                      status_odd;
    logic [11:0]               missing_added;
    logic                      older_generation;
    logic                      heading_from_radar;
    logic [10:0]               display_angle;
    logic [10:0]               display_bearing;
    logic signed [RANGE_W-1:0] decoded_range;
    logic [11:0]               true_heading;
    logic [31:0]               missing_total;
    logic [31:0]               broken_total;
  } res_t;

  // classified spoke; decoded_range holds the newer-generation range
  typedef struct packed {
    res_t             res;
    logic [RAW_W-1:0] raw24;
  } ent_t;

endpackage
`default_nettype wire

[rtl/core/rshd_if.sv]
// request channels for spoke headers and decoded results
`timescale 1ns / 1ps
`default_nettype none
interface rshd_hdr_if;
  import rshd_pkg::*;
  logic valid;
  logic ready;
  hdr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rshd_res_if;
  import rshd_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/rshd_front.sv]
// front: configuration, sequence and heading state, header classification
`timescale 1ns / 1ps
`default_nettype none
module rshd_front import rshd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  rshd_hdr_if.sink                   hdr_i,
  output ent_t                       push_ent_o,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i
);

  logic [11:0] variation_q;
  logic        var_valid_q;
  logic        ignore_q;
  logic [11:0] rotation_q;
  logic [11:0] heading_q, heading_d;
  logic [11:0] expected_q;
  logic        known_q;
  logic [31:0] missing_q, missing_d;
  logic [31:0] broken_q, broken_d;

  hdr_t                      d;
  logic                      accept;
  logic                      length_ok;
  logic                      odd;
  logic                      older;
  logic                      use_radar;
  logic [11:0]               scan_next;
  logic [11:0]               gap;
  logic [11:0]               added;
  logic [11:0]               h_radar;
  logic [11:0]               hdt;
  logic [11:0]               angle_off;
  logic [11:0]               bear_sum;
  logic signed [15:0]        coarse_range;
  logic signed [15:0]        fine_range;
  logic signed [15:0]        small_adj;
  logic signed [16:0]        small_rnd;
  logic signed [RANGE_W-1:0] meters_new;

  assign d            = hdr_i.data;
  assign hdr_i.ready  = push_ready_i;
  assign push_valid_o = hdr_i.valid;
  assign accept       = hdr_i.valid && push_ready_i;

  always_comb begin
    length_ok = d.header_length == HDR_LEN;
    odd       = (d.status_byte != STATUS_PLAIN) && (d.status_byte != STATUS_ALT);
    older     = d.mark_word == OLD_MARK;
    scan_next = d.seq_num + 12'd1;
    gap       = d.seq_num - expected_q;
    priority if (!length_ok) begin
      added = 12'd1;
    end else if (known_q && (d.seq_num != expected_q)) begin
      added = gap;
    end else begin
      added = 12'd0;
    end

    // newer generation range, divided by four toward zero
    coarse_range = signed'(d.mark_word[31:16]);
    fine_range   = signed'(d.range_word[15:0]);
    small_adj    = (fine_range == -16'sd1) ? 16'sd0 : fine_range;
    small_rnd    = 17'(small_adj) + (small_adj[15] ? 17'sd3 : 17'sd0);
    if (coarse_range == NARROW_FLAG) begin
      meters_new = RANGE_W'(small_rnd >>> 2);
    end else begin
      meters_new = {{(RANGE_W - 22){coarse_range[15]}}, coarse_range, 6'b0};
    end

    use_radar = (d.heading_word != HEADING_ABSENT) && !older && !ignore_q && var_valid_q;
    h_radar   = d.heading_word[11:0] + variation_q;
    heading_d = heading_q;
    if (length_ok && use_radar) begin
      heading_d = h_radar;
    end
    hdt       = heading_d + rotation_q;
    angle_off = d.angle_word[11:0] + ANGLE_OFFSET;
    bear_sum  = angle_off + hdt;

    missing_d = missing_q + 32'(added);
    broken_d  = broken_q + 32'(length_ok && odd);
  end

  always_comb begin
    push_ent_o                        = '0;
    push_ent_o.res.missing_added      = added;
    push_ent_o.res.true_heading       = heading_d;
    push_ent_o.res.missing_total      = missing_d;
    push_ent_o.res.broken_total       = broken_d;
    if (length_ok) begin
      push_ent_o.res.spoke_drawn        = 1'b1;
      push_ent_o.res.status_odd         = odd;
      push_ent_o.res.older_generation   = older;
      push_ent_o.res.heading_from_radar = use_radar;
      push_ent_o.res.display_angle      = angle_off[11:1];
      push_ent_o.res.display_bearing    = bear_sum[11:1];
      push_ent_o.res.decoded_range      = older ? '0 : meters_new;
      push_ent_o.raw24                  = older ? d.range_word[RAW_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variation_q <= '0;
      var_valid_q <= 1'b0;
      ignore_q    <= 1'b0;
      rotation_q  <= '0;
      heading_q   <= '0;
      expected_q  <= '0;
      known_q     <= 1'b0;
      missing_q   <= '0;
      broken_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VARIATION:       variation_q <= cfg_data_i;
        CFG_VARIATION_VALID: var_valid_q <= cfg_data_i[0];
        CFG_IGNORE_HEADING:  ignore_q    <= cfg_data_i[0];
        CFG_ROTATION:        rotation_q  <= cfg_data_i;
        CFG_INITIAL_HEADING: heading_q   <= cfg_data_i;
        default: ;
      endcase
    end else if (accept) begin
      heading_q  <= heading_d;
      expected_q <= scan_next;
      known_q    <= 1'b1;
      missing_q  <= missing_d;
      broken_q   <= broken_d;
    end
  end

  a_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cfg_we_i |=> known_q && (expected_q == $past(scan_next)))
    else $error("expected scan number not resynced after request");

endmodule
`default_nettype wire

[rtl/core/rshd_queue.sv]
// short queue of classified spokes between front and back
`timescale 1ns / 1ps
`default_nettype none
module rshd_queue import rshd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  ent_t      push_ent_i,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  output ent_t      pop_ent_o,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ent_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_ent_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> pop_valid_o)
    else $error("pushed spoke not visible at queue head");

endmodule
`default_nettype wire

[rtl/core/rshd_back.sv]
// back: pipelined range square root and result register
`timescale 1ns / 1ps
`default_nettype none
module rshd_back import rshd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  ent_t      pop_ent_i,
  input  wire logic pop_valid_i,
  output logic      pop_ready_o,
  rshd_res_if.source res_o
);

  logic                 advance;
  logic                 mul_valid_q;
  ent_t                 mul_ent_q;
  logic [2*RAW_W-1:0]   mul_sq_q;
  logic [SQRT_STEPS:0]  stg_valid_q;
  ent_t                 stg_ent_q [SQRT_STEPS+1];
  logic [SQRT_W-1:0]    stg_n_q   [SQRT_STEPS+1];
  logic [SQRT_W-1:0]    stg_r_q   [SQRT_STEPS+1];
  logic                 out_valid_q;
  res_t                 out_res_q;
  res_t                 out_res_d;

  // whole pipeline holds while the result register is stalled
  assign advance     = !out_valid_q || res_o.ready;
  assign pop_ready_o = advance;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      stg_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      mul_valid_q <= pop_valid_i;
      stg_valid_q <= {stg_valid_q[SQRT_STEPS-1:0], mul_valid_q};
      out_valid_q <= stg_valid_q[SQRT_STEPS];
    end
  end

  // square, then scale by fifty
  always_ff @(posedge clk_i) begin
    if (advance) begin
      mul_ent_q    <= pop_ent_i;
      mul_sq_q     <= {{RAW_W{1'b0}}, pop_ent_i.raw24} * {{RAW_W{1'b0}}, pop_ent_i.raw24};
      stg_ent_q[0] <= mul_ent_q;
      stg_n_q[0]   <= {{(SQRT_W - 2*RAW_W){1'b0}}, mul_sq_q} * SQRT_W'(RANGE_SCALE);
      stg_r_q[0]   <= '0;
    end
  end

  // one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SQRT_W+1:0] diff;

    assign diff = {2'b00, stg_n_q[k]} - {2'b00, stg_r_q[k]} - {2'b00, BIT};

    always_ff @(posedge clk_i) begin
      if (advance) begin
        stg_ent_q[k+1] <= stg_ent_q[k];
        if (!diff[SQRT_W+1]) begin
          stg_n_q[k+1] <= diff[SQRT_W-1:0];
          stg_r_q[k+1] <= (stg_r_q[k] >> 1) + BIT;
        end else begin
          stg_n_q[k+1] <= stg_n_q[k];
          stg_r_q[k+1] <= stg_r_q[k] >> 1;
        end
      end
    end
  end

  always_comb begin
    out_res_d = stg_ent_q[SQRT_STEPS].res;
    if (stg_ent_q[SQRT_STEPS].res.older_generation) begin
      out_res_d.decoded_range = signed'(stg_r_q[SQRT_STEPS][RANGE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= out_res_d;
    end
  end

  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_q[SQRT_STEPS] |->
      stg_n_q[SQRT_STEPS] <= {stg_r_q[SQRT_STEPS][SQRT_W-2:0], 1'b0})
    else $error("square root remainder out of bound");

  a_older_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.older_generation |-> !out_res_q.decoded_range[RANGE_W-1])
    else $error("older generation range negative");

  a_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.spoke_drawn |->
      (out_res_q.decoded_range == '0) && (out_res_q.missing_added == 12'd1))
    else $error("dropped spoke carries range or wrong missing count");

endmodule
`default_nettype wire

[rtl/core/radar_spoke_header_decoder_top.sv]
// top level of the radar spoke header decoder
//
// hdr_i takes one decoded 24-byte spoke header per request (valid/ready).
// res_o gives one result per header, in order (valid/ready).
// cfg_we_i/cfg_idx_i/cfg_data_i write the five settings; write only when
// no header is in flight. writing the initial heading also loads the
// stored heading.
// the front updates sequence, counter and heading state in the cycle a
// header is taken and pushes the classified spoke into a short queue.
// the back squares the older-generation range, scales it and takes the
// square root one result bit per stage.
// a header passes the queue, the square and scale registers, the
// 28-stage square root and the result register on its way to res_o.
// throughput: one header per cycle while res_o does not stall.
// when res_o stalls the whole back holds; the queue then fills and hdr_i
// drops ready once it is full.
// reset clears counters, sequence tracking, stored heading and settings.
`timescale 1ns / 1ps
`default_nettype none
module radar_spoke_header_decoder_top import rshd_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  rshd_hdr_if.sink                   hdr_i,
  rshd_res_if.source                 res_o
);

  ent_t push_ent, pop_ent;
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;

  rshd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .hdr_i        (hdr_i),
    .push_ent_o   (push_ent),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  rshd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_ent_i   (push_ent),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_ent_o    (pop_ent),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  rshd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_ent_i   (pop_ent),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

[verif/tb_radar_spoke_header_decoder_top.sv]
// self-checking testbench for the radar spoke header decoder top level
`timescale 1ns / 1ps
module tb_radar_spoke_header_decoder_top;
  import rshd_pkg::*;

  localparam int          SPOKES       = SPOKE_COUNT;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;
  // first index past the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

  typedef struct packed {
    logic [11:0] variation;
    logic        var_ok;
    logic        hdg_ignore;
    logic [11:0] rotation;
    logic [11:0] init;
  } setting_t;

  typedef struct packed {
    logic     reconfig;
    setting_t cfg;
    hdr_t     hdr;
    logic     typed;
    res_t     want;
  } vector_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rshd_hdr_if hdr_if ();
  rshd_res_if res_if ();

  radar_spoke_header_decoder_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .hdr_i      (hdr_if),
    .res_o      (res_if)
  );

  // decoder state mirror
  setting_t    cur;
  logic [11:0] next_scan;
  logic        scan_known;
  logic [11:0] stored_heading;
  logic [31:0] miss_total;
  logic [31:0] odd_total;

  res_t        decoded_q[$];
  int unsigned error_count;
  int unsigned n_hdr, n_dropped, n_older, n_radar, n_settings;
  logic        idle_on;
  int unsigned stall_left;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned rem, root, probe;
    rem   = n;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - root - probe;
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic res_t decode_spoke(hdr_t h);
    res_t            r;
    int unsigned     gap, sweep, hdt;
    int              big, little, raw, hsum;
    longint unsigned r24;
    r = '0;
    if (h.header_length != HDR_LEN) begin
      r.missing_added = 12'd1;
      miss_total      = miss_total + 1;
      next_scan       = h.seq_num + 12'd1;
      scan_known      = 1'b1;
    end else begin
      r.spoke_drawn = 1'b1;
      if (h.status_byte != STATUS_PLAIN && h.status_byte != STATUS_ALT) begin
        r.status_odd = 1'b1;
        odd_total    = odd_total + 1;
      end
      if (scan_known && h.seq_num != next_scan) begin
        if (h.seq_num > next_scan) gap = h.seq_num - next_scan;
        else gap = SPOKES + h.seq_num - next_scan;
        miss_total      = miss_total + gap;
        r.missing_added = (gap > 4095) ? 12'hFFF : gap[11:0];
      end
      next_scan  = h.seq_num + 12'd1;
      scan_known = 1'b1;

      if (h.mark_word == OLD_MARK) begin
        r.older_generation = 1'b1;
        r24                = h.range_word[23:0];
        r.decoded_range    = RANGE_W'(root_floor(64'd50 * r24 * r24));
      end else begin
        big    = $signed(h.mark_word[31:16]);
        little = $signed(h.range_word[15:0]);
        if (big == int'(NARROW_FLAG)) raw = (little == -1) ? 0 : little;
        else raw = big * 256;
        r.decoded_range = RANGE_W'(raw / 4);
      end

      if (h.heading_word != HEADING_ABSENT && !r.older_generation &&
          !cur.hdg_ignore && cur.var_ok) begin
        hsum = int'($signed(h.heading_word)) + int'($signed(cur.variation));
        hsum = ((hsum % SPOKES) + SPOKES) % SPOKES;
        r.heading_from_radar = 1'b1;
        stored_heading       = hsum[11:0];
        hdt                  = hsum + cur.rotation;
      end else begin
        hdt = stored_heading + cur.rotation;
      end
      sweep             = h.angle_word + ANGLE_OFFSET;
      r.display_angle   = 11'(sweep >> 1);
      r.display_bearing = 11'((sweep + hdt) >> 1);
    end
    r.true_heading  = stored_heading;
    r.missing_total = miss_total;
    r.broken_total  = odd_total;
    return r;
  endfunction

  function automatic hdr_t random_header();
    hdr_t        h;
    int unsigned pick;
    h.header_length = ($urandom_range(0, 15) == 0) ? 8'($urandom) : HDR_LEN;
    pick = $urandom_range(0, 9);
    h.status_byte = (pick < 5) ? STATUS_PLAIN : (pick < 8) ? STATUS_ALT : 8'($urandom);
    h.seq_num = ($urandom_range(0, 9) == 0) ? 12'($urandom) : next_scan;
    pick = $urandom_range(0, 9);
    h.mark_word = (pick < 4) ? OLD_MARK :
                  (pick < 5) ? {NARROW_FLAG, 16'($urandom)} : $urandom;
    h.angle_word   = 16'($urandom);
    h.heading_word = ($urandom_range(0, 7) == 0) ? HEADING_ABSENT : 16'($urandom);
    h.range_word   = ($urandom_range(0, 9) == 0) ? {16'($urandom), 16'hFFFF} : $urandom;
    return h;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_VARIATION:       cur.variation  = val;
      CFG_VARIATION_VALID: cur.var_ok     = val[0];
      CFG_IGNORE_HEADING:  cur.hdg_ignore = val[0];
      CFG_ROTATION:        cur.rotation   = val;
      CFG_INITIAL_HEADING: begin
        cur.init       = val;
        stored_heading = val;
      end
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(CFG_SPARE + 3'($urandom_range(0, 2)), 12'($urandom));
    write_reg(CFG_VARIATION, s.variation);
    write_reg(CFG_VARIATION_VALID, {11'($urandom), s.var_ok});
    write_reg(CFG_IGNORE_HEADING, {11'($urandom), s.hdg_ignore});
    write_reg(CFG_ROTATION, s.rotation);
    write_reg(CFG_INITIAL_HEADING, s.init);
    cfg_we_i   <= 1'b0;
    n_settings = n_settings + 1;
  endtask

  task automatic wait_drained();
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_header(hdr_t h, logic typed, res_t want);
    res_t pred;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      hdr_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    hdr_if.valid <= 1'b1;
    hdr_if.data  <= h;
    do @(posedge clk_i); while (!(hdr_if.valid && hdr_if.ready));
    pred = decode_spoke(h);
    decoded_q.push_back(typed ? want : pred);
    n_hdr     = n_hdr + 1;
    n_dropped = n_dropped + !pred.spoke_drawn;
    n_older   = n_older + pred.older_generation;
    n_radar   = n_radar + pred.heading_from_radar;
  endtask

  function automatic setting_t random_setting();
    setting_t s;
    s.variation  = 12'($urandom);
    s.var_ok     = 1'($urandom);
    s.hdg_ignore = 1'($urandom);
    s.rotation   = 12'($urandom);
    s.init       = 12'($urandom);
    return s;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count = error_count + 1;
      if (error_count <= MAX_REPORTS)
        $display("%s mismatch: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic compare_result(res_t want, res_t got);
    check_field("spoke_drawn", want.spoke_drawn, got.spoke_drawn);
    check_field("status_odd", want.status_odd, got.status_odd);
    check_field("missing_added", want.missing_added, got.missing_added);
    check_field("older_generation", want.older_generation, got.older_generation);
    check_field("heading_from_radar", want.heading_from_radar, got.heading_from_radar);
    check_field("display_angle", want.display_angle, got.display_angle);
    check_field("display_bearing", want.display_bearing, got.display_bearing);
    check_field("decoded_range", want.decoded_range, got.decoded_range);
    check_field("true_heading", want.true_heading, got.true_heading);
    check_field("missing_total", want.missing_total, got.missing_total);
    check_field("broken_total", want.broken_total, got.broken_total);
  endtask

  // result side back-pressure
  initial begin
    res_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left   = stall_left - 1;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left   = $urandom_range(0, 9);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (decoded_q.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= MAX_REPORTS)
          $display("result with nothing expected: %h", res_if.data);
      end else begin
        compare_result(decoded_q.pop_front(), res_if.data);
      end
    end
  end

  initial begin
    vector_t  tbl[$];
    setting_t s;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    hdr_if.valid = 1'b0;
    hdr_if.data  = '0;

    cur            = '0;
    next_scan      = '0;
    scan_known     = 1'b0;
    stored_heading = '0;
    miss_total     = '0;
    odd_total      = '0;
    error_count    = 0;
    n_hdr          = 0;
    n_dropped      = 0;
    n_older        = 0;
    n_radar        = 0;
    n_settings     = 0;
    idle_on        = 1'b1;

    // first spoke, drop, odd status at field extremes
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd0, OLD_MARK, 16'd0, 16'sd0, 32'd0}, 1'b1,
      res_t'{1'b1, 1'b0, 12'd0, 1'b1, 1'b0, 11'd1536, 11'd1536, 28'sd0, 12'd0,
             32'd0, 32'd0}});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{8'h00, STATUS_PLAIN, 12'd5, 32'd0, 16'd0, 16'sd0, 32'd0}, 1'b1,
      res_t'{1'b0, 1'b0, 12'd1, 1'b0, 1'b0, 11'd0, 11'd0, 28'sd0, 12'd0,
             32'd1, 32'd0}});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, 8'hFF, 12'd6, 32'd0, 16'hFFFF, HEADING_ABSENT, 32'hFFFF_FFFF},
      1'b1,
      res_t'{1'b1, 1'b1, 12'd0, 1'b0, 1'b0, 11'd1535, 11'd1535, 28'sd0, 12'd0,
             32'd1, 32'd1}});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{8'hFF, STATUS_ALT, 12'd4095, 32'hFFFF_FFFF, 16'hFFFF, 16'sh7FFF,
             32'hFFFF_FFFF}, 1'b0, res_t'(0)});
    // sequence gaps and wrap
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_ALT, 12'd3, 32'h7FFF_0000, 16'd1, 16'sd0, 32'd0},
      1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd1, 32'h8000_1234, 16'd4095, 16'sd1,
             32'h1234_5678}, 1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd4095, OLD_MARK, 16'd2048, 16'sd0,
             32'hFFFF_FFFF}, 1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd0, OLD_MARK, 16'd1024, 16'sd0, 32'd1},
      1'b0, res_t'(0)});
    // narrow range flag with small range extremes
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd1, 32'h0080_0000, 16'd300, 16'sd0,
             32'h0000_FFFF}, 1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd2, 32'h0080_FFFF, 16'd301, 16'sd0,
             32'h0000_8000}, 1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd3, 32'h0080_5555, 16'd302, 16'sd0,
             32'hFFFF_7FFF}, 1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd4, 32'h0080_AAAA, 16'd303, 16'sd0,
             32'h0000_FFFB}, 1'b0, res_t'(0)});
    // near miss of the older mark, then a repeated scan number
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, 8'h00, 12'd9, 32'h0E0D_4401, 16'd777, 16'sd0, 32'd0},
      1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd9, 32'd0, 16'd778, 16'sd0, 32'd0},
      1'b0, res_t'(0)});
    // heading source selection
    tbl.push_back(vector_t'{1'b1, setting_t'{12'h800, 1'b1, 1'b0, 12'hFFF, 12'hFFF},
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd10, 32'd0, 16'd100, 16'sd100, 32'd0},
      1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd11, 32'd0, 16'd200, HEADING_ABSENT, 32'd0},
      1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd12, 32'd0, 16'd300, -16'sd1, 32'd0},
      1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd13, OLD_MARK, 16'd400, 16'sd5, 32'd1000},
      1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b1, setting_t'{12'h7FF, 1'b1, 1'b1, 12'h000, 12'h000},
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd14, 32'd0, 16'd500, 16'sh7FFF, 32'd0},
      1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b1, setting_t'{12'h7FF, 1'b1, 1'b0, 12'd1234, 12'd77},
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd15, 32'd0, 16'd600, 16'sh7FFF, 32'd0},
      1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b0, setting_t'(0),
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd16, 32'd0, 16'd700, 16'sh8001, 32'd0},
      1'b0, res_t'(0)});
    tbl.push_back(vector_t'{1'b1, setting_t'{12'h000, 1'b0, 1'b0, 12'd2048, 12'd3000},
      hdr_t'{HDR_LEN, STATUS_PLAIN, 12'd17, 32'd0, 16'd800, 16'sd10, 32'd0},
      1'b0, res_t'(0)});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tbl[i]) begin
      if (tbl[i].reconfig) begin
        hdr_if.valid <= 1'b0;
        wait_drained();
        apply_setting(tbl[i].cfg);
      end
      send_header(tbl[i].hdr, tbl[i].typed, tbl[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: s = setting_t'{12'h7FF, 1'b1, 1'b0, 12'hFFF, 12'hFFF};
        1: s = setting_t'{12'h800, 1'b1, 1'b0, 12'h000, 12'h000};
        3: begin
          s = random_setting();
          s.hdg_ignore = 1'b1;
        end
        4: s = random_setting();
        default: begin
          s = random_setting();
          s.var_ok     = 1'b1;
          s.hdg_ignore = 1'b0;
        end
      endcase
      hdr_if.valid <= 1'b0;
      wait_drained();
      apply_setting(s);
      idle_on = (p != NUM_PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0 && p != NUM_PHASES - 1) idle_on = ($urandom_range(0, 3) != 0);
        send_header(random_header(), 1'b0, res_t'(0));
      end
    end

    hdr_if.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d spoke headers: %0d dropped, %0d older generation, %0d radar heading",
             n_hdr, n_dropped, n_older, n_radar);
    $display("%0d register settings applied, %0d mismatches", n_settings, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
